@@ src/cet_pkg.sv @@
// cet_pkg: shared constants, codes, entry and control structs for the
// cylinder extent table. No dependencies.
`default_nettype none

package cet_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int TAG_CHARS   = 8;
	localparam int TAG_W       = 64;
	localparam int CYL_W       = 32;
	localparam int BPB_W       = 21;
	localparam int SLOT_W      = 5;
	localparam int NSLOT_W     = 4;
	localparam int DIV_W       = 32;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;

	localparam logic [CYL_W-1:0] MB_BYTES        = CYL_W'(1024 * 1024);
	localparam logic [BPB_W-1:0] DEF_BLOCK_BYTES = BPB_W'(512);

	localparam logic [CYL_W-1:0] FIRST_RST = CYL_W'(2);
	localparam logic [CYL_W-1:0] LAST_RST  = '0;
	localparam logic [CYL_W-1:0] BPC_RST   = '0;
	localparam logic [BPB_W-1:0] BPB_RST   = BPB_W'(512);

	typedef enum logic [2:0] {
		OP_APPEND,
		OP_ADD_AT,
		OP_ADD_RANGE,
		OP_RESIZE,
		OP_RENAME,
		OP_DELETE,
		OP_GAP,
		OP_READ
	} op_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_FULL,
		ST_EMPTY,
		ST_DUP,
		ST_NOSPACE,
		ST_OVERLAP,
		ST_RANGE,
		ST_NOGAP
	} status_t;

	typedef enum logic [1:0] {
		REG_FIRST,
		REG_LAST,
		REG_BPC,
		REG_BPB
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CV_START,
		S_CV_DIV1,
		S_CV_MUL,
		S_CV_DIV2_GO,
		S_CV_DIV2,
		S_DISPATCH,
		S_SCAN_RD,
		S_SCAN_USE,
		S_AFTER_SCAN,
		S_RMW_RD,
		S_RMW_USE,
		S_CHK_I_RD,
		S_CHK_I_USE,
		S_CHK_J_RD,
		S_CHK_J_USE,
		S_CHK_END,
		S_DEL_RD,
		S_DEL_WR,
		S_GAP_TOP,
		S_GAP_RD,
		S_GAP_USE,
		S_GAP_FIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [CYL_W-1:0] lo;
		logic [CYL_W-1:0] hi;
		logic [CYL_W-1:0] ty;
	} entry_t;

	typedef struct packed {
		logic [CYL_W-1:0] first;
		logic [CYL_W-1:0] last;
		logic [CYL_W-1:0] bpc;
		logic [BPB_W-1:0] bpb;
	} cfg_t;

	typedef struct packed {
		op_t              op;
		logic [SLOT_W-1:0] slot;
		logic [TAG_W-1:0]  tag;
		logic [CYL_W-1:0]  sc;
		logic [CYL_W-1:0]  ec;
		logic [CYL_W-1:0]  mb;
		logic [CYL_W-1:0]  ty;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [NSLOT_W-1:0] new_slot;
		logic [CYL_W-1:0]   gap_first;
		logic [CYL_W-1:0]   gap_last;
		entry_t             entry;
		logic [CNT_W-1:0]   count;
	} res_t;

	// cut at the first zero byte
	function automatic logic [TAG_W-1:0] clean_tag(input logic [TAG_W-1:0] t);
		logic [TAG_W-1:0] r;
		logic stop;
		r = '0;
		stop = 1'b0;
		for (int i = 0; i < TAG_CHARS; i++) begin
			if (t[8*i +: 8] == 8'h00) stop = 1'b1;
			if (!stop) r[8*i +: 8] = t[8*i +: 8];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/cet_ram.sv @@
// cet_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`default_nettype none

module cet_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ src/cet_div.sv @@
// cet_div: iterative unsigned divider, one quotient bit per cycle.
// Depends on cet_pkg.
`default_nettype none

module cet_div import cet_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output logic                  done,
	output logic      [DIV_W-1:0] quotient
);

	localparam int CW = $clog2(DIV_W);

	logic          busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q, quo_q, dsr_q;
	logic [DIV_W:0]   trial, diff;
	logic             fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = !diff[DIV_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ src/cet_seq.sv @@
// cet_seq: operation sequencer around the entry memory and the divider.
// Depends on cet_pkg, cet_ram, cet_div.
`default_nettype none

module cet_seq import cet_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_go,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	input  wire logic  res_ready,
	output logic       busy,
	output logic       res_valid,
	output res_t       res
);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	op_t               op_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TAG_W-1:0]  tag_q;
	logic [CYL_W-1:0]  sc_q, ec_q, mb_q, ty_q;
	logic [CYL_W-1:0]  per_mb_q, total_q, cyls_q, start_q;
	logic [CNT_W-1:0]  idx_q, j_q, n_q;
	logic              dup_q;
	entry_t            a_q, old_q, ent_out_q;
	status_t           status_q, chk_q;
	logic [NSLOT_W-1:0] new_slot_q;
	logic [CYL_W-1:0]  gf_q, gl_q, bs_q, be_q;
	logic [CYL_W:0]    cur_q, nxt_q, blen_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	entry_t            ram_wdata, rd;
	logic [$bits(entry_t)-1:0] ram_rdata;

	logic              div_start, div_done;
	logic [DIV_W-1:0]  div_dividend, div_divisor, div_q;

	logic [BPB_W-1:0]  bb_eff;
	logic [CYL_W-1:0]  prod_lo, app_end, add_end, rs_nh, hi1;
	logic              app_nospace, add_range_bad, add_nospace, dup_hit, skip_en, is_add;
	logic [CNT_W-1:0]  idx_nx, j_nx;
	status_t           self_code, pair_code;
	logic [CYL_W:0]    last33, g_lo, g_hi, ge_raw, ge_c, glen;
	logic              g_cov, g_nx, g_better;
	entry_t            app_ent, add_ent, ren_ent, rsz_ent;

	cet_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_ENTRIES)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	cet_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_q)
	);

	assign rd      = entry_t'(ram_rdata);
	assign bb_eff  = (cfg.bpb == '0) ? DEF_BLOCK_BYTES : cfg.bpb;
	assign prod_lo = mb_q * per_mb_q;
	assign app_end = start_q + cyls_q - CYL_W'(1);
	assign add_end = (op_q == OP_ADD_AT) ? sc_q + cyls_q - CYL_W'(1) : ec_q;
	assign rs_nh   = rd.lo + cyls_q - CYL_W'(1);
	assign hi1     = rd.hi + CYL_W'(1);
	assign idx_nx  = idx_q + CNT_W'(1);
	assign j_nx    = j_q + CNT_W'(1);
	assign is_add  = (op_q == OP_APPEND) || (op_q == OP_ADD_AT) || (op_q == OP_ADD_RANGE);
	assign skip_en = (op_q == OP_RESIZE) || (op_q == OP_RENAME);
	assign dup_hit = !(skip_en && idx_q == slot_q) && rd.tag == tag_q;

	assign app_nospace   = (start_q > cfg.last) || (app_end > cfg.last);
	assign add_range_bad = (op_q == OP_ADD_RANGE) && (ec_q < sc_q);
	assign add_nospace   = (sc_q < cfg.first) || (add_end > cfg.last);

	assign app_ent = '{tag: tag_q, lo: start_q, hi: app_end, ty: ty_q};
	assign add_ent = '{tag: tag_q, lo: sc_q, hi: add_end, ty: ty_q};
	assign ren_ent = '{tag: tag_q, lo: rd.lo, hi: rd.hi, ty: ty_q};
	assign rsz_ent = '{tag: tag_q, lo: rd.lo, hi: rs_nh, ty: ty_q};

	always_comb begin
		if (rd.lo < cfg.first || rd.hi > cfg.last) self_code = ST_NOSPACE;
		else if (rd.lo > rd.hi) self_code = ST_RANGE;
		else if (rd.tag == '0) self_code = ST_EMPTY;
		else self_code = ST_OK;
	end

	always_comb begin
		if (a_q.tag == rd.tag) pair_code = ST_DUP;
		else if (a_q.lo <= rd.hi && rd.lo <= a_q.hi) pair_code = ST_OVERLAP;
		else pair_code = ST_OK;
	end

	// gap walk, positions one bit wider than a cylinder
	assign last33   = {1'b0, cfg.last};
	assign g_lo     = {1'b0, rd.lo};
	assign g_hi     = {1'b0, rd.hi};
	assign g_cov    = (g_lo <= cur_q) && (cur_q <= g_hi);
	assign g_nx     = (g_lo > cur_q) && (g_lo < nxt_q);
	assign ge_raw   = nxt_q - (CYL_W+1)'(1);
	assign ge_c     = (ge_raw > last33) ? last33 : ge_raw;
	assign glen     = ge_c - cur_q + (CYL_W+1)'(1);
	assign g_better = (ge_c >= cur_q) && (glen > blen_q);

	always_comb begin
		state_d      = state_q;
		ram_we       = 1'b0;
		ram_waddr    = cnt_q[IDX_W-1:0];
		ram_wdata    = app_ent;
		ram_raddr    = idx_q[IDX_W-1:0];
		div_start    = 1'b0;
		div_dividend = MB_BYTES;
		div_divisor  = DIV_W'(bb_eff);
		res_valid    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (item_go) begin
					if (item.op == OP_APPEND || item.op == OP_ADD_AT || item.op == OP_RESIZE)
						state_d = S_CV_START;
					else
						state_d = S_DISPATCH;
				end
			end
			S_CV_START: begin
				if (cfg.bpc == '0) state_d = S_DISPATCH;
				else begin
					div_start = 1'b1;
					state_d   = S_CV_DIV1;
				end
			end
			S_CV_DIV1: if (div_done) state_d = S_CV_MUL;
			S_CV_MUL: state_d = S_CV_DIV2_GO;
			S_CV_DIV2_GO: begin
				div_start    = 1'b1;
				div_dividend = total_q + cfg.bpc - CYL_W'(1);
				div_divisor  = cfg.bpc;
				state_d      = S_CV_DIV2;
			end
			S_CV_DIV2: if (div_done) state_d = S_DISPATCH;
			S_DISPATCH: begin
				if (is_add) begin
					if (cnt_q >= CNT_W'(MAX_ENTRIES) || tag_q == '0) state_d = S_DONE;
					else if (cnt_q == '0) state_d = S_AFTER_SCAN;
					else state_d = S_SCAN_RD;
				end else if (op_q == OP_GAP) begin
					state_d = S_GAP_TOP;
				end else if (slot_q >= cnt_q) begin
					state_d = S_DONE;
				end else if (op_q == OP_DELETE) begin
					state_d = S_DEL_RD;
				end else if (op_q == OP_READ) begin
					state_d = S_RMW_RD;
				end else if (tag_q == '0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: state_d = S_SCAN_USE;
			S_SCAN_USE: state_d = (idx_nx >= cnt_q) ? S_AFTER_SCAN : S_SCAN_RD;
			S_AFTER_SCAN: begin
				if (dup_q) state_d = S_DONE;
				else begin
					case (op_q)
						OP_APPEND: begin
							ram_we  = !app_nospace;
							state_d = S_DONE;
						end
						OP_ADD_AT, OP_ADD_RANGE: begin
							if (add_range_bad || add_nospace) state_d = S_DONE;
							else begin
								ram_we    = 1'b1;
								ram_wdata = add_ent;
								state_d   = S_CHK_I_RD;
							end
						end
						default: state_d = S_RMW_RD;
					endcase
				end
			end
			S_RMW_RD: begin
				ram_raddr = slot_q[IDX_W-1:0];
				state_d   = S_RMW_USE;
			end
			S_RMW_USE: begin
				ram_waddr = slot_q[IDX_W-1:0];
				case (op_q)
					OP_RENAME: begin
						ram_we    = 1'b1;
						ram_wdata = ren_ent;
						state_d   = S_DONE;
					end
					OP_RESIZE: begin
						if (rs_nh > cfg.last) state_d = S_DONE;
						else begin
							ram_we    = 1'b1;
							ram_wdata = rsz_ent;
							state_d   = S_CHK_I_RD;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_CHK_I_RD: state_d = S_CHK_I_USE;
			S_CHK_I_USE: begin
				if (self_code != ST_OK || idx_nx >= n_q) state_d = S_CHK_END;
				else state_d = S_CHK_J_RD;
			end
			S_CHK_J_RD: begin
				ram_raddr = j_q[IDX_W-1:0];
				state_d   = S_CHK_J_USE;
			end
			S_CHK_J_USE: begin
				if (pair_code != ST_OK) state_d = S_CHK_END;
				else if (j_nx >= n_q) state_d = S_CHK_I_RD;
				else state_d = S_CHK_J_RD;
			end
			S_CHK_END: begin
				// failed resize puts the old entry back
				ram_waddr = slot_q[IDX_W-1:0];
				ram_wdata = old_q;
				ram_we    = (op_q == OP_RESIZE) && (chk_q != ST_OK);
				state_d   = S_DONE;
			end
			S_DEL_RD: begin
				ram_raddr = idx_nx[IDX_W-1:0];
				state_d   = (idx_nx >= cnt_q) ? S_DONE : S_DEL_WR;
			end
			S_DEL_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[IDX_W-1:0];
				ram_wdata = rd;
				state_d   = S_DEL_RD;
			end
			S_GAP_TOP: begin
				if (cur_q > last33) state_d = S_DONE;
				else if (cnt_q == '0) state_d = S_GAP_FIN;
				else state_d = S_GAP_RD;
			end
			S_GAP_RD: state_d = S_GAP_USE;
			S_GAP_USE: begin
				if (g_cov) state_d = S_GAP_TOP;
				else if (idx_nx >= cnt_q) state_d = S_GAP_FIN;
				else state_d = S_GAP_RD;
			end
			S_GAP_FIN: state_d = S_GAP_TOP;
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_AFTER_SCAN && !dup_q && op_q == OP_APPEND && !app_nospace)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (state_q == S_CHK_END && op_q != OP_RESIZE && chk_q == ST_OK)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (state_q == S_DEL_RD && idx_nx >= cnt_q)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (item_go) begin
					op_q       <= item.op;
					slot_q     <= item.slot;
					tag_q      <= clean_tag(item.tag);
					sc_q       <= item.sc;
					ec_q       <= item.ec;
					mb_q       <= item.mb;
					ty_q       <= item.ty;
					cyls_q     <= CYL_W'(1);
					status_q   <= ST_OK;
					new_slot_q <= '0;
					gf_q       <= '0;
					gl_q       <= '0;
					ent_out_q  <= '0;
				end
			end
			S_CV_DIV1: if (div_done) per_mb_q <= div_q;
			S_CV_MUL: total_q <= prod_lo;
			S_CV_DIV2: if (div_done) cyls_q <= (div_q == '0) ? CYL_W'(1) : div_q;
			S_DISPATCH: begin
				idx_q   <= '0;
				dup_q   <= 1'b0;
				start_q <= cfg.first;
				cur_q   <= {1'b0, cfg.first};
				blen_q  <= '0;
				bs_q    <= '0;
				be_q    <= '0;
				if (is_add) begin
					if (cnt_q >= CNT_W'(MAX_ENTRIES)) status_q <= ST_FULL;
					else if (tag_q == '0) status_q <= ST_EMPTY;
				end else if (op_q != OP_GAP) begin
					if (slot_q >= cnt_q) status_q <= ST_RANGE;
					else if (op_q == OP_DELETE) idx_q <= slot_q;
					else if (op_q != OP_READ && tag_q == '0) status_q <= ST_EMPTY;
				end
			end
			S_SCAN_USE: begin
				if (dup_hit) dup_q <= 1'b1;
				if (hi1 > start_q) start_q <= hi1;
				idx_q <= idx_nx;
			end
			S_AFTER_SCAN: begin
				if (dup_q) status_q <= ST_DUP;
				else begin
					case (op_q)
						OP_APPEND: begin
							if (app_nospace) status_q <= ST_NOSPACE;
							else new_slot_q <= NSLOT_W'(cnt_q);
						end
						OP_ADD_AT, OP_ADD_RANGE: begin
							if (add_range_bad) status_q <= ST_RANGE;
							else if (add_nospace) status_q <= ST_NOSPACE;
							else begin
								idx_q <= '0;
								n_q   <= cnt_q + CNT_W'(1);
							end
						end
						default: ;
					endcase
				end
			end
			S_RMW_USE: begin
				case (op_q)
					OP_READ: ent_out_q <= rd;
					OP_RESIZE: begin
						old_q <= rd;
						if (rs_nh > cfg.last) status_q <= ST_NOSPACE;
						else begin
							idx_q <= '0;
							n_q   <= cnt_q;
						end
					end
					default: ;
				endcase
			end
			S_CHK_I_USE: begin
				a_q <= rd;
				if (self_code != ST_OK) chk_q <= self_code;
				else if (idx_nx >= n_q) chk_q <= ST_OK;
				else j_q <= idx_nx;
			end
			S_CHK_J_USE: begin
				if (pair_code != ST_OK) chk_q <= pair_code;
				else if (j_nx >= n_q) idx_q <= idx_nx;
				else j_q <= j_nx;
			end
			S_CHK_END: begin
				if (op_q == OP_RESIZE) status_q <= chk_q;
				else if (chk_q == ST_OK) new_slot_q <= NSLOT_W'(cnt_q);
				else status_q <= ST_OVERLAP;
			end
			S_DEL_WR: idx_q <= idx_nx;
			S_GAP_TOP: begin
				if (cur_q > last33) begin
					if (blen_q == '0) status_q <= ST_NOGAP;
					else begin
						gf_q <= bs_q;
						gl_q <= be_q;
					end
				end else begin
					nxt_q <= last33 + (CYL_W+1)'(1);
					idx_q <= '0;
				end
			end
			S_GAP_USE: begin
				if (g_cov) cur_q <= g_hi + (CYL_W+1)'(1);
				else if (g_nx) nxt_q <= g_lo;
				idx_q <= idx_nx;
			end
			S_GAP_FIN: begin
				if (g_better) begin
					blen_q <= glen;
					bs_q   <= cur_q[CYL_W-1:0];
					be_q   <= ge_c[CYL_W-1:0];
				end
				cur_q <= nxt_q;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	assign res.status    = status_q;
	assign res.new_slot  = new_slot_q;
	assign res.gap_first = gf_q;
	assign res.gap_last  = gl_q;
	assign res.entry     = ent_out_q;
	assign res.count     = cnt_q;

endmodule

`default_nettype wire

@@ src/cylinder_extent_table.sv @@
// cylinder_extent_table: top level with register port, word handshakes
// and result register. Depends on cet_pkg and cet_seq.
//
//   channel   direction  handshake                    content
//   item      in         item_valid / item_stall      op, slot, tag, cylinders, size, type
//   result    out        result_valid / result_stall  status, slot, gap, entry, count
//   config    in         psel/penable/pwrite/pready   four registers at 0x0..0xc
//
// one word at a time; a word first runs the size conversion (two divides) where needed,
// then visits entries in the single-read-port entry memory: add-at, add-range and
// resize check every entry pair, the gap walk rescans the entries at each step.
// reset empties the table at once; entries are held without reset.
// the next word is taken while a finished result waits in the output register.
`default_nettype none

module cylinder_extent_table import cet_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [2:0]         op,
	input  wire logic [SLOT_W-1:0]  slot,
	input  wire logic [TAG_W-1:0]   tag,
	input  wire logic [CYL_W-1:0]   start_cylinder,
	input  wire logic [CYL_W-1:0]   end_cylinder,
	input  wire logic [CYL_W-1:0]   size_mb,
	input  wire logic [CYL_W-1:0]   type_word,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [2:0]              status,
	output logic [NSLOT_W-1:0]      new_slot,
	output logic [CYL_W-1:0]        gap_first,
	output logic [CYL_W-1:0]        gap_last,
	output logic [TAG_W-1:0]        entry_tag,
	output logic [CYL_W-1:0]        entry_low,
	output logic [CYL_W-1:0]        entry_high,
	output logic [CYL_W-1:0]        entry_type,
	output logic [CNT_W-1:0]        entry_count,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	cfg_t     cfg_q;
	item_t    item;
	res_t     res, res_q;
	logic     busy, item_go, seq_res_valid, res_ready, out_valid_q, cfg_we;
	reg_idx_t reg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first <= FIRST_RST;
			cfg_q.last  <= LAST_RST;
			cfg_q.bpc   <= BPC_RST;
			cfg_q.bpb   <= BPB_RST;
		end else if (cfg_we) begin
			case (reg_idx)
				REG_FIRST: cfg_q.first <= pwdata;
				REG_LAST:  cfg_q.last  <= pwdata;
				REG_BPC:   cfg_q.bpc   <= pwdata;
				REG_BPB:   cfg_q.bpb   <= pwdata[BPB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FIRST: prdata = cfg_q.first;
			REG_LAST:  prdata = cfg_q.last;
			REG_BPC:   prdata = cfg_q.bpc;
			REG_BPB:   prdata = PDATA_W'(cfg_q.bpb);
			default:   prdata = '0;
		endcase
	end

	assign item_stall = busy;
	assign item_go    = item_valid && !busy;

	assign item.op   = op_t'(op);
	assign item.slot = slot;
	assign item.tag  = tag;
	assign item.sc   = start_cylinder;
	assign item.ec   = end_cylinder;
	assign item.mb   = size_mb;
	assign item.ty   = type_word;

	cet_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_go  (item_go),
		.item     (item),
		.cfg      (cfg_q),
		.res_ready(res_ready),
		.busy     (busy),
		.res_valid(seq_res_valid),
		.res      (res)
	);

	// output register
	assign res_ready = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (seq_res_valid && res_ready) out_valid_q <= 1'b1;
		else if (!result_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (seq_res_valid && res_ready) res_q <= res;
	end

	assign result_valid = out_valid_q;
	assign status       = res_q.status;
	assign new_slot     = res_q.new_slot;
	assign gap_first    = res_q.gap_first;
	assign gap_last     = res_q.gap_last;
	assign entry_tag    = res_q.entry.tag;
	assign entry_low    = res_q.entry.lo;
	assign entry_high   = res_q.entry.hi;
	assign entry_type   = res_q.entry.ty;
	assign entry_count  = res_q.count;

endmodule

`default_nettype wire
